FILE: hw/rtl/szs_pkg.sv
// ============================================================================
// szs_pkg
// Shared constants, command codes and engine handshake types for the sparse
// row z-score scaler.
// ============================================================================
package szs_pkg;

    // Sizes of the gene map and of the per-row tables.
    localparam int TOTAL_GENES = 32768;
    localparam int ROWS        = 4096;
    localparam int GENE_AW     = $clog2(TOTAL_GENES);
    localparam int ROW_AW      = $clog2(ROWS);

    // Length of the clearing pass after reset, which covers both tables.
    localparam int CLR_LEN = (TOTAL_GENES > ROWS) ? TOTAL_GENES : ROWS;
    localparam int CNT_W   = $clog2(CLR_LEN);

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int GENE_W   = 15;
    localparam int ROW_W    = 12;
    localparam int SAMPLE_W = 28;
    localparam int VAL_W    = 28;
    localparam int CELL_W   = 21;
    localparam int CLIP_W   = 27;

    // Stored widths.
    localparam int SUM_W  = 48;
    localparam int SQ_W   = 60;
    localparam int SQI_W  = 40;
    localparam int MEAN_W = 28;
    localparam int INV_W  = 32;
    localparam int MAP_W  = 1 + ROW_W;
    localparam int ACC_W  = SUM_W + SQ_W;
    localparam int STAT_W = MEAN_W + INV_W + VAL_W;

    // Divider operand widths.
    localparam int DVD_W = 64;
    localparam int DIV_W = 40;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_MAP        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FINALIZE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BACKGROUND = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

    // Request to the finalize engine for one row.
    typedef struct packed {
        logic              start;
        logic [CELL_W-1:0] n;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sq;
    } fin_req_t;

    // Row statistics returned by the finalize engine.
    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] mean;
        logic [INV_W-1:0]  inv_sd;
        logic [VAL_W-1:0]  background;
    } fin_rsp_t;

endpackage

FILE: hw/rtl/szs_ram.sv
// ============================================================================
// szs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module szs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

FILE: hw/rtl/szs_div.sv
// ============================================================================
// szs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module szs_div
    import szs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [$clog2(DVD_W)-1:0] cnt_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DVD_W-1:0]         quo_reg;
    logic [DIV_W-1:0]         div_reg;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(DVD_W))'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/szs_sqrt.sv
// ============================================================================
// szs_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ============================================================================
module szs_sqrt
    import szs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] radicand,
    output logic             done,
    output logic [31:0]      root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        fits;

    // One root digit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg, v_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    // Control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[61:0], 2'b00};
            rem_reg  <= fits ? diff[33:0] : rem_sh[33:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hw/rtl/szs_fin.sv
// ============================================================================
// szs_fin
// Finalize engine: turns one row's sums into mean, reciprocal standard
// deviation and background z score, using a shared divider and a root unit.
// ============================================================================
module szs_fin
    import szs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fin_req_t req,
    output fin_rsp_t rsp
);

    typedef enum logic [7:0] {
        F_IDLE = 8'b0000_0001,
        F_MEAN = 8'b0000_0010,
        F_EX2  = 8'b0000_0100,
        F_DIFF = 8'b0000_1000,
        F_VAR  = 8'b0001_0000,
        F_SQRT = 8'b0010_0000,
        F_INV  = 8'b0100_0000,
        F_BG   = 8'b1000_0000
    } fstate_t;

    fstate_t state_reg;
    logic    go_reg;
    logic    done_reg;

    logic [CELL_W-1:0] n_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [55:0]       prod_reg;
    logic [60:0]       ex2_reg;
    logic [60:0]       diff_reg;
    logic [61:0]       var_reg;
    logic              small_reg;
    logic [DIV_W-1:0]  sd_reg;
    logic [INV_W-1:0]  inv_reg;
    logic [VAL_W-1:0]  bg_reg;

    logic [CELL_W-1:0] half;
    logic [DVD_W-1:0]  dvd;
    logic [DIV_W-1:0]  dvs;
    logic              div_start;
    logic              div_done;
    logic [DVD_W-1:0]  quo;
    logic              sqrt_start;
    logic              sqrt_done;
    logic [31:0]       root;
    logic              var_small;
    logic [DVD_W-1:0]  radicand;
    logic [39:0]       msq;
    logic [DIV_W-1:0]  sd_raw;
    logic [DIV_W-1:0]  sd_val;
    logic [MEAN_W-1:0] mean_sat;
    logic [INV_W-1:0]  inv_sat;
    logic [VAL_W-1:0]  bg_mag;
    logic [55:0]       mean_sq;

    // Operand selection for the shared divider.
    always_comb
    begin
        half = n_reg >> 1;
        dvd  = '0;
        dvs  = DIV_W'(n_reg);
        unique case (state_reg)
            F_MEAN:
            begin
                dvd = DVD_W'(sum_reg) + DVD_W'(half);
            end
            F_EX2:
            begin
                dvd = DVD_W'(sq_reg) + DVD_W'(half);
            end
            F_VAR:
            begin
                dvd = DVD_W'(diff_reg);
                dvs = DIV_W'(n_reg - 1'b1);
            end
            F_INV:
            begin
                dvd = (DVD_W'(1) << 32) + DVD_W'(sd_reg >> 1);
                dvs = sd_reg;
            end
            F_BG:
            begin
                dvd = DVD_W'({mean_reg, 16'd0}) + DVD_W'(sd_reg >> 1);
                dvs = sd_reg;
            end
            default:
            begin
                dvd = '0;
            end
        endcase
    end

    assign div_start  = go_reg && (state_reg == F_MEAN || state_reg == F_EX2 ||
                                   state_reg == F_VAR || state_reg == F_INV ||
                                   state_reg == F_BG);
    assign sqrt_start = go_reg && (state_reg == F_SQRT);

    // Derived values from the registered partial results.
    always_comb
    begin
        mean_sq   = mean_reg * mean_reg;
        var_small = (var_reg[61:48] == '0);
        radicand  = var_small ? {var_reg[47:0], 16'd0} : DVD_W'(var_reg);
        msq       = 40'((prod_reg + 56'd32768) >> 16);
        sd_raw    = small_reg ? DIV_W'(root) : DIV_W'({root, 8'd0});
        sd_val    = (sd_raw == '0) ? DIV_W'(65536) : sd_raw;
        mean_sat  = (quo[DVD_W-1:MEAN_W] != '0) ? '1 : quo[MEAN_W-1:0];
        inv_sat   = (quo[DVD_W-1:INV_W] != '0) ? '1 : quo[INV_W-1:0];
        bg_mag    = (quo[DVD_W-1:VAL_W-1] != '0) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                  : quo[VAL_W-1:0];
    end

    szs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    szs_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (radicand),
        .done     (sqrt_done),
        .root     (root)
    );

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            go_reg   <= 1'b0;
            unique case (state_reg)
                F_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= F_MEAN;
                        go_reg    <= 1'b1;
                    end
                end
                F_MEAN:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_EX2;
                        go_reg    <= 1'b1;
                    end
                end
                F_EX2:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_DIFF;
                    end
                end
                F_DIFF:
                begin
                    state_reg <= F_VAR;
                    go_reg    <= 1'b1;
                end
                F_VAR:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_SQRT;
                        go_reg    <= 1'b1;
                    end
                end
                F_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg <= F_INV;
                        go_reg    <= 1'b1;
                    end
                end
                F_INV:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_BG;
                        go_reg    <= 1'b1;
                    end
                end
                F_BG:
                begin
                    if (div_done)
                    begin
                        state_reg <= F_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Partial results.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req.start)
        begin
            n_reg   <= req.n;
            sum_reg <= req.sum;
            sq_reg  <= req.sq;
        end
        if (state_reg == F_MEAN && div_done)
        begin
            mean_reg <= mean_sat;
        end
        if (state_reg == F_EX2 && go_reg)
        begin
            prod_reg <= mean_sq;
        end
        if (state_reg == F_EX2 && div_done)
        begin
            ex2_reg <= quo[60:0];
        end
        if (state_reg == F_DIFF)
        begin
            diff_reg <= (ex2_reg > 61'(msq)) ? ex2_reg - 61'(msq) : '0;
        end
        if (state_reg == F_VAR && div_done)
        begin
            var_reg <= 62'(diff_reg) + 62'(quo);
        end
        if (state_reg == F_SQRT && go_reg)
        begin
            small_reg <= var_small;
        end
        if (state_reg == F_SQRT && sqrt_done)
        begin
            sd_reg <= sd_val;
        end
        if (state_reg == F_INV && div_done)
        begin
            inv_reg <= inv_sat;
        end
        if (state_reg == F_BG && div_done)
        begin
            // Background is minus the quotient, saturated at the field bound.
            bg_reg <= VAL_W'(~bg_mag + 1'b1);
        end
    end

    assign rsp.done       = done_reg;
    assign rsp.mean       = mean_reg;
    assign rsp.inv_sd     = inv_reg;
    assign rsp.background = bg_reg;

endmodule

FILE: hw/rtl/sparse_row_zscore_scaler.sv
// ============================================================================
// sparse_row_zscore_scaler
// Per-row standardization of a sparse matrix: gene map, per-row sums, a
// finalize pass over all rows and scaled or background lookups.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: command; tdata: gene, row, sample
//   m_*      out        tuser: hit; tdata: result_value, result_row
//   apb      in/out     cell_count at 0x0, clip_max at 0x4
//
// Accumulate, scale and background commands are paced by the chain of
// registered memory reads; map and unused commands need no read. Finalize
// walks all 4096 rows, paced by the bit-serial divider and root unit. Clear
// zeroes one row per cycle. After reset a clearing pass zeroes the gene map
// and sums.
// An item is taken while a finished result still waits at the output; a
// result is held in its state until the output register frees.
// ============================================================================
module sparse_row_zscore_scaler
    import szs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // gene[14:0], row[26:15], sample[54:27], pad
    input  logic [2:0]  s_tuser,   // command[2:0]
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[27:0], result_row[39:28]
    output logic        m_tuser,   // hit
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_CELL_COUNT = 1'b0;
    localparam logic REG_CLIP_MAX   = 1'b1;

    typedef enum logic [11:0] {
        S_INIT = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_MAP  = 12'b0000_0000_0100,
        S_ACC  = 12'b0000_0000_1000,
        S_SCM  = 12'b0000_0001_0000,
        S_SCR  = 12'b0000_0010_0000,
        S_BG   = 12'b0000_0100_0000,
        S_FRD  = 12'b0000_1000_0000,
        S_FGO  = 12'b0001_0000_0000,
        S_FRUN = 12'b0010_0000_0000,
        S_CLR  = 12'b0100_0000_0000,
        S_RESP = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [CELL_W-1:0]   cell_count_reg;
    logic [CLIP_W-1:0]   clip_max_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [GENE_W-1:0]   gene_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [ROW_AW-1:0]   sel_row_reg;
    logic [SQI_W-1:0]    sq_reg;
    logic [59:0]         prod_reg;
    logic                neg_reg;
    logic [VAL_W-1:0]    rv_reg;
    logic [ROW_W-1:0]    rr_reg;
    logic                rh_reg;
    logic                ov_reg;
    logic [39:0]         od_reg;
    logic                ou_reg;

    logic [CMD_W-1:0]    in_cmd;
    logic [GENE_W-1:0]   in_gene;
    logic [ROW_W-1:0]    in_row;
    logic [SAMPLE_W-1:0] in_sample;
    logic                accept;
    logic                cfg_write;
    logic                in_gene_ok;
    logic                in_row_ok;
    logic                gene_ok;

    logic               map_we;
    logic [GENE_AW-1:0] map_waddr;
    logic [MAP_W-1:0]   map_wdata;
    logic               map_re;
    logic [MAP_W-1:0]   map_rdata;
    logic               acc_we;
    logic [ROW_AW-1:0]  acc_waddr;
    logic [ACC_W-1:0]   acc_wdata;
    logic               acc_re;
    logic [ROW_AW-1:0]  acc_raddr;
    logic [ACC_W-1:0]   acc_rdata;
    logic               st_we;
    logic [STAT_W-1:0]  st_wdata;
    logic               st_re;
    logic [ROW_AW-1:0]  st_raddr;
    logic [STAT_W-1:0]  st_rdata;

    fin_req_t fin_req;
    fin_rsp_t fin_rsp;

    logic                map_hit;
    logic [ROW_AW-1:0]   map_row;
    logic [55:0]         sample_sq;
    logic [SQI_W-1:0]    sq_rnd;
    logic [SUM_W:0]      sum_add;
    logic [SQ_W:0]       sq_add;
    logic [MEAN_W-1:0]   st_mean;
    logic [INV_W-1:0]    st_inv;
    logic [VAL_W-1:0]    st_bg;
    logic                sc_neg;
    logic [SAMPLE_W-1:0] sc_d;
    logic [59:0]         sc_prod;
    logic [43:0]         sc_mag;
    logic [VAL_W-1:0]    sc_neg_mag;
    logic [CLIP_W-1:0]   sc_pos;
    logic [VAL_W-1:0]    sc_value;
    logic                out_load;
    logic                last_row;

    // Unpack the input transaction.
    assign in_cmd     = s_tuser;
    assign in_gene    = s_tdata[14:0];
    assign in_row     = s_tdata[26:15];
    assign in_sample  = s_tdata[54:27];
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_gene_ok = ({17'd0, in_gene} < 32'(TOTAL_GENES));
    assign in_row_ok  = ({20'd0, in_row} < 32'(ROWS));
    assign gene_ok    = ({17'd0, gene_reg} < 32'(TOTAL_GENES));

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_CELL_COUNT: prdata = 32'(cell_count_reg);
            REG_CLIP_MAX:   prdata = 32'(clip_max_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= CELL_W'(2);
            clip_max_reg   <= CLIP_W'(655360);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_CELL_COUNT: cell_count_reg <= pwdata[CELL_W-1:0];
                REG_CLIP_MAX:   clip_max_reg   <= pwdata[CLIP_W-1:0];
                default:        cell_count_reg <= cell_count_reg;
            endcase
        end
    end

    // Datapath helpers for accumulate and scale.
    always_comb
    begin
        map_hit    = gene_ok && map_rdata[MAP_W-1];
        map_row    = ROW_AW'(map_rdata[ROW_W-1:0]);
        sample_sq  = sample_reg * sample_reg;
        sq_rnd     = SQI_W'((sample_sq + 56'd32768) >> 16);
        sum_add    = (SUM_W+1)'(acc_rdata[SUM_W-1:0]) + (SUM_W+1)'(sample_reg);
        sq_add     = (SQ_W+1)'(acc_rdata[ACC_W-1:SUM_W]) + (SQ_W+1)'(sq_reg);
        st_mean    = st_rdata[MEAN_W-1:0];
        st_inv     = st_rdata[MEAN_W+INV_W-1:MEAN_W];
        st_bg      = st_rdata[STAT_W-1:MEAN_W+INV_W];
        sc_neg     = (sample_reg < st_mean);
        sc_d       = sc_neg ? st_mean - sample_reg : sample_reg - st_mean;
        sc_prod    = sc_d * st_inv;
        sc_mag     = 44'((prod_reg + 60'd32768) >> 16);
        sc_neg_mag = (sc_mag[43:VAL_W-1] != '0) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                : sc_mag[VAL_W-1:0];
        sc_pos     = (sc_mag > 44'(clip_max_reg)) ? clip_max_reg
                                                  : sc_mag[CLIP_W-1:0];
        // Negative results saturate below; positive ones are capped at clip_max.
        sc_value   = (neg_reg && sc_mag != '0) ? VAL_W'(~sc_neg_mag + 1'b1)
                                               : VAL_W'(sc_pos);
        last_row   = (cnt_reg == CNT_W'(ROWS - 1));
        out_load   = (state_reg == S_RESP) && (!ov_reg || m_tready);
    end

    // Finalize engine request.
    assign fin_req.start = (state_reg == S_FGO);
    assign fin_req.n     = (cell_count_reg < CELL_W'(2)) ? CELL_W'(2) : cell_count_reg;
    assign fin_req.sum   = acc_rdata[SUM_W-1:0];
    assign fin_req.sq    = acc_rdata[ACC_W-1:SUM_W];

    // Sequencer and memory port control.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        map_we     = 1'b0;
        map_waddr  = GENE_AW'(in_gene);
        map_wdata  = {1'b1, in_row};
        map_re     = 1'b0;
        acc_we     = 1'b0;
        acc_waddr  = sel_row_reg;
        acc_wdata  = {sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0],
                      sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0]};
        acc_re     = 1'b0;
        acc_raddr  = map_row;
        st_we      = 1'b0;
        st_wdata   = {fin_rsp.background, fin_rsp.inv_sd, fin_rsp.mean};
        st_re      = 1'b0;
        st_raddr   = map_row;
        unique case (state_reg)
            S_INIT:
            begin
                map_we    = 1'b1;
                map_waddr = GENE_AW'(cnt_reg);
                map_wdata = '0;
                acc_we    = 1'b1;
                acc_waddr = ROW_AW'(cnt_reg);
                acc_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CLR_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_MAP:
                        begin
                            map_we = in_gene_ok && in_row_ok;
                        end
                        CMD_ACCUMULATE, CMD_SCALE:
                        begin
                            map_re     = 1'b1;
                            state_next = S_MAP;
                        end
                        CMD_FINALIZE:
                        begin
                            cnt_next   = '0;
                            state_next = S_FRD;
                        end
                        CMD_BACKGROUND:
                        begin
                            st_re      = 1'b1;
                            st_raddr   = ROW_AW'(in_row);
                            state_next = in_row_ok ? S_BG : S_RESP;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MAP:
            begin
                if (cmd_reg == CMD_ACCUMULATE)
                begin
                    acc_re     = map_hit;
                    state_next = map_hit ? S_ACC : S_IDLE;
                end
                else
                begin
                    st_re      = map_hit;
                    state_next = map_hit ? S_SCM : S_RESP;
                end
            end
            S_ACC:
            begin
                acc_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_SCM:
            begin
                state_next = S_SCR;
            end
            S_SCR, S_BG:
            begin
                state_next = S_RESP;
            end
            S_FRD:
            begin
                acc_re     = 1'b1;
                acc_raddr  = ROW_AW'(cnt_reg);
                state_next = S_FGO;
            end
            S_FGO:
            begin
                state_next = S_FRUN;
            end
            S_FRUN:
            begin
                if (fin_rsp.done)
                begin
                    st_we = 1'b1;
                    if (last_row)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_FRD;
                    end
                end
            end
            S_CLR:
            begin
                acc_we    = 1'b1;
                acc_waddr = ROW_AW'(cnt_reg);
                acc_wdata = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (last_row)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= in_cmd;
            gene_reg   <= in_gene;
            row_reg    <= in_row;
            sample_reg <= in_sample;
            rv_reg     <= '0;
            rr_reg     <= '0;
            rh_reg     <= 1'b0;
        end
        if (state_reg == S_MAP)
        begin
            sel_row_reg <= map_row;
            sq_reg      <= sq_rnd;
            if (!map_hit)
            begin
                rv_reg <= '0;
                rr_reg <= '0;
                rh_reg <= 1'b0;
            end
        end
        if (state_reg == S_SCM)
        begin
            prod_reg <= sc_prod;
            neg_reg  <= sc_neg;
        end
        if (state_reg == S_SCR)
        begin
            rv_reg <= sc_value;
            rr_reg <= ROW_W'(sel_row_reg);
            rh_reg <= 1'b1;
        end
        if (state_reg == S_BG)
        begin
            rv_reg <= st_bg;
            rr_reg <= row_reg;
            rh_reg <= 1'b1;
        end
        if (state_reg == S_FRUN && fin_rsp.done && last_row)
        begin
            rv_reg <= '0;
            rr_reg <= '0;
            rh_reg <= 1'b1;
        end
        if (out_load)
        begin
            od_reg <= {rr_reg, rv_reg};
            ou_reg <= rh_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

    // Gene map: valid bit and selected row per gene.
    szs_ram #(.WIDTH(MAP_W), .DEPTH(TOTAL_GENES)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (GENE_AW'(in_gene)),
        .rdata (map_rdata)
    );

    // Per-row sum and sum of squares.
    szs_ram #(.WIDTH(ACC_W), .DEPTH(ROWS)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // Per-row mean, reciprocal deviation and background.
    szs_ram #(.WIDTH(STAT_W), .DEPTH(ROWS)) u_stat_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (ROW_AW'(cnt_reg)),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    szs_fin u_fin (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fin_req),
        .rsp   (fin_rsp)
    );

    // The finalize engine only reports while the row walk waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_rsp.done |-> (state_reg == S_FRUN))
        else $error("finalize result outside the row walk");

    // A pending result is never dropped while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && ov_reg && !m_tready |=> (state_reg == S_RESP))
        else $error("result left its state while the output was full");

    // Items are taken only after the full clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && ($past(state_reg) == S_INIT)
            |-> ($past(cnt_reg) == CNT_W'(CLR_LEN - 1)))
        else $error("clearing pass cut short");

endmodule

FILE: tb/sv/sparse_row_zscore_scaler_test.sv
// ============================================================================
// sparse_row_zscore_scaler_test
// Self-checking bench for the sparse row z-score scaler. A class keeps its own
// copy of the gene map, row sums and row statistics. It predicts each result
// from the commands the block accepts and checks the output stream in order.
// Directed commands come first. Random phases follow under several register
// settings and with random idle cycles on both streams.
// ============================================================================
module sparse_row_zscore_scaler_test;
    import szs_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic             hit;
    } result_t;

    // Predicts row statistics and checks results against the oldest expectation.
    class row_zscore_book;
        bit                 gene_valid [TOTAL_GENES];
        bit [ROW_W-1:0]     gene_row   [TOTAL_GENES];
        bit [63:0]          sum        [ROWS];
        bit [63:0]          sq_sum     [ROWS];
        bit [63:0]          mean       [ROWS];
        bit [63:0]          inv_sd     [ROWS];
        bit [VAL_W-1:0]     background [ROWS];
        bit [CELL_W-1:0]    cells;
        bit [CLIP_W-1:0]    clip;
        result_t            pending[$];
        int                 mismatches;
        int                 results_seen;

        function new();
            cells = 2;
            clip  = 655360;
            foreach (sum[r])
            begin
                sum[r]    = 0;
                sq_sum[r] = 0;
            end
        endfunction

        static function bit [63:0] int_sqrt(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Negative values saturate at -2^27; positive ones are capped at clip.
        function bit [VAL_W-1:0] saturate(bit negative, bit [63:0] mag);
            if (negative && mag != 0)
            begin
                if (mag > 64'd134217728)
                    mag = 64'd134217728;
                return VAL_W'(-mag);
            end
            if (mag > clip)
                mag = clip;
            if (mag > 64'd134217727)
                mag = 64'd134217727;
            return VAL_W'(mag);
        endfunction

        function void finalize_rows();
            bit [63:0] n, m, msq, ex2, diff, var_q, sd, inv, bg;
            n = (cells < 2) ? 64'd2 : 64'(cells);
            for (int r = 0; r < ROWS; r++)
            begin
                m = (sum[r] + n / 2) / n;
                if (m > 64'd268435455)
                    m = 64'd268435455;
                msq   = (m * m + 64'd32768) >> 16;
                ex2   = (sq_sum[r] + n / 2) / n;
                diff  = (ex2 > msq) ? ex2 - msq : 64'd0;
                var_q = diff + diff / (n - 1);
                if (var_q < (64'd1 << 48))
                    sd = int_sqrt(var_q << 16);
                else
                    sd = int_sqrt(var_q) << 8;
                if (sd == 0)
                    sd = 64'd65536;
                inv = ((64'd1 << 32) + sd / 2) / sd;
                if (inv > 64'hFFFF_FFFF)
                    inv = 64'hFFFF_FFFF;
                bg = ((m << 16) + sd / 2) / sd;
                mean[r]       = m;
                inv_sd[r]     = inv;
                background[r] = saturate(1'b1, bg);
            end
        endfunction

        // Notes one accepted command and queues the result it causes, if any.
        function void note_item(logic [CMD_W-1:0] cmd, logic [GENE_W-1:0] gene,
                                logic [ROW_W-1:0] row, logic [SAMPLE_W-1:0] sample);
            result_t   res;
            bit [63:0] s, sq, d, mag;
            int        r;
            bit        neg;
            res = '0;
            case (cmd)
                CMD_MAP:
                begin
                    gene_valid[gene] = 1'b1;
                    gene_row[gene]   = row;
                end
                CMD_ACCUMULATE:
                begin
                    if (gene_valid[gene])
                    begin
                        r = gene_row[gene];
                        s = sum[r] + sample;
                        sum[r] = (s > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : s;
                        sq = (64'(sample) * 64'(sample) + 64'd32768) >> 16;
                        s  = sq_sum[r] + sq;
                        sq_sum[r] = (s > 64'h0FFF_FFFF_FFFF_FFFF) ?
                                    64'h0FFF_FFFF_FFFF_FFFF : s;
                    end
                end
                CMD_FINALIZE:
                begin
                    finalize_rows();
                    res.hit = 1'b1;
                    pending.push_back(res);
                end
                CMD_SCALE:
                begin
                    if (gene_valid[gene])
                    begin
                        r   = gene_row[gene];
                        neg = sample < mean[r];
                        d   = neg ? mean[r] - sample : 64'(sample) - mean[r];
                        mag = (d * inv_sd[r] + 64'd32768) >> 16;
                        res.value = saturate(neg, mag);
                        res.row   = ROW_W'(r);
                        res.hit   = 1'b1;
                    end
                    pending.push_back(res);
                end
                CMD_BACKGROUND:
                begin
                    res.value = background[row];
                    res.row   = row;
                    res.hit   = 1'b1;
                    pending.push_back(res);
                end
                CMD_CLEAR:
                begin
                    foreach (sum[i])
                    begin
                        sum[i]    = 0;
                        sq_sum[i] = 0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: value %0h row %0d hit %0b",
                             got.value, got.row, got.hit);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected value %0h row %0d hit %0b, got %0h %0d %0b",
                             want.value, want.row, want.hit, got.value, got.row, got.hit);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;    // gene[14:0], row[26:15], sample[54:27], pad
    logic [2:0]  s_tuser;    // command[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // result_value[27:0], result_row[39:28]
    logic        m_tuser;    // hit
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    row_zscore_book book;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_request;
    int          items_sent;
    logic [GENE_W-1:0] gene_pool [16];
    logic [ROW_W-1:0]  row_pool  [8];

    sparse_row_zscore_scaler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_result({m_tdata[27:0], m_tdata[39:28], m_tuser});
    end

    // Run limit.
    initial
    begin
        #400_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        s_tvalid <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == 3'd0)
            book.cells = data[CELL_W-1:0];
        else
            book.clip = data[CLIP_W-1:0];
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [GENE_W-1:0] gene,
                                input logic [ROW_W-1:0] row,
                                input logic [SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, sample, row, gene};
        do
            @(posedge clk);
        while (!s_tready);
        book.note_item(cmd, gene, row, sample);
        items_sent++;
    endtask

    // Drains all expected results, then idles long enough for a clear to finish.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (5000)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(3) == 0)
            return SAMPLE_W'($urandom());
        return SAMPLE_W'($urandom_range(20'hFFFFF));
    endfunction

    // Mostly commands on a pool of mapped genes, with some noise.
    task automatic random_chunk(input int count, input int finalize_at, input bit pressure);
        int pick;
        logic [GENE_W-1:0] g;
        for (int i = 0; i < count; i++)
        begin
            case ((i / 40) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (pressure && i == 30)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
                hold_request   = 1'b1;
                for (int k = 0; k < 40; k++)
                    send_command(CMD_SCALE, gene_pool[k % 16], '0, pick_sample());
            end
            if (i == finalize_at)
                send_command(CMD_FINALIZE, '0, '0, '0);
            g = gene_pool[$urandom_range(15)];
            pick = $urandom_range(99);
            if (pick < 8)
                send_command(CMD_MAP, g, row_pool[$urandom_range(7)], pick_sample());
            else if (pick < 48)
                send_command(CMD_ACCUMULATE, g, ROW_W'($urandom()), pick_sample());
            else if (pick < 76)
                send_command(CMD_SCALE, g, ROW_W'($urandom()), pick_sample());
            else if (pick < 80)
                send_command(CMD_SCALE, GENE_W'($urandom()), ROW_W'($urandom()),
                             pick_sample());
            else if (pick < 92)
                send_command(CMD_BACKGROUND, g, $urandom_range(3) == 0 ?
                             ROW_W'($urandom()) : row_pool[$urandom_range(7)],
                             pick_sample());
            else if (pick < 94)
                send_command(CMD_CLEAR, g, '0, pick_sample());
            else
                send_command(CMD_CLEAR + 3'(1 + $urandom_range(1)), GENE_W'($urandom()),
                             ROW_W'($urandom()), SAMPLE_W'($urandom()));
        end
    endtask

    // Main sequence.
    initial
    begin
        book           = new();
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        foreach (gene_pool[i])
            gene_pool[i] = GENE_W'($urandom());
        foreach (row_pool[i])
            row_pool[i] = ROW_W'($urandom());

        // A cell count below two behaves as two.
        write_register(3'd0, 32'd1);
        write_register(3'd4, 32'd655360);

        // Directed: extremes, unselected genes, unused codes, every command.
        send_command(CMD_MAP, 15'd0, 12'd0, '0);
        send_command(CMD_MAP, 15'd32767, 12'd4095, '0);
        send_command(CMD_MAP, 15'd100, 12'd7, '0);
        send_command(CMD_ACCUMULATE, 15'd0, '0, 28'd0);
        send_command(CMD_ACCUMULATE, 15'd0, '0, 28'hFFFFFFF);
        send_command(CMD_ACCUMULATE, 15'd32767, '0, 28'hFFFFFFF);
        send_command(CMD_ACCUMULATE, 15'd100, '0, 28'h0010000);
        send_command(CMD_ACCUMULATE, 15'd100, '0, 28'h0030000);
        send_command(CMD_ACCUMULATE, 15'd5, '0, 28'h0050000);
        send_command(3'd6, 15'h7FFF, 12'hFFF, 28'hFFFFFFF);
        send_command(3'd7, 15'd0, 12'd0, 28'd0);
        send_command(CMD_FINALIZE, '0, '0, '0);
        send_command(CMD_SCALE, 15'd0, '0, 28'd0);
        send_command(CMD_SCALE, 15'd32767, '0, 28'hFFFFFFF);
        send_command(CMD_SCALE, 15'd100, '0, 28'h0000001);
        send_command(CMD_SCALE, 15'd100, '0, 28'hFFFFFFF);
        send_command(CMD_SCALE, 15'd5, '0, 28'h0050000);
        send_command(CMD_BACKGROUND, '0, 12'd0, '0);
        send_command(CMD_BACKGROUND, '0, 12'd4095, '0);
        send_command(CMD_BACKGROUND, '0, 12'd7, '0);
        send_command(CMD_BACKGROUND, '0, 12'd3, '0);
        send_command(CMD_CLEAR, '0, '0, '0);
        send_command(CMD_MAP, 15'd100, 12'd4095, '0);
        send_command(CMD_SCALE, 15'd100, '0, 28'h0020000);
        wait_quiet();

        foreach (gene_pool[i])
            send_command(CMD_MAP, gene_pool[i], row_pool[i % 8], '0);

        // Small random cell count.
        write_register(3'd0, $urandom_range(3, 40));
        write_register(3'd4, $urandom_range(1 << 16, 1 << 22));
        random_chunk(225, 120, 1'b1);
        wait_quiet();

        // Cell count of 2^20, zero cap.
        write_register(3'd0, 32'd1048576);
        write_register(3'd4, 32'd0);
        random_chunk(225, 100, 1'b0);
        wait_quiet();

        // Largest cap.
        write_register(3'd4, 32'd134217727);
        random_chunk(225, -1, 1'b0);
        s_tvalid <= 1'b0;

        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        $display("Covered %0d commands and %0d results over three cell-count settings",
                 items_sent, book.results_seen);
        $display("and cap values of default, zero, random and maximum.");
        if (book.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
